[hw/rtl/skf_pkg.sv]
// ----------------------------------------------------------------------------
// skf_pkg
// Types, register indexes and the control-store program of the scalar
// Kalman filter core.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int FIELD_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MDW       = 16;  // multiplier digit width
  localparam int PC_W      = 5;
  localparam int PROG_LEN  = 27;

  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATE_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_GAIN  = 3'd4;

  localparam logic [FIELD_W-1:0] OUT_MAX = 32'h7fff_ffff;
  localparam logic [FIELD_W-1:0] OUT_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    UOP_MUL,
    UOP_ADD,
    UOP_SUB,
    UOP_DIV,
    UOP_JSTART,
    UOP_JZERO,
    UOP_INITDONE,
    UOP_DONE,
    UOP_FAULT
  } op_t;

  typedef enum logic [3:0] {
    SRC_M,
    SRC_U,
    SRC_A,
    SRC_B,
    SRC_C,
    SRC_R,
    SRC_Q,
    SRC_X,
    SRC_P,
    SRC_T,
    SRC_XP,
    SRC_PP,
    SRC_DEN,
    SRC_K
  } src_t;

  typedef enum logic [2:0] {
    DST_T,
    DST_XP,
    DST_PP,
    DST_DEN,
    DST_K,
    DST_X,
    DST_P
  } dst_t;

  typedef struct packed {
    op_t             op;
    src_t            src_a;
    src_t            src_b;
    dst_t            dst;
    logic [PC_W-1:0] target;
  } uword_t;

  localparam logic [PC_W-1:0] PC_NONE  = 5'd0;
  localparam logic [PC_W-1:0] PC_RUN   = 5'd6;
  localparam logic [PC_W-1:0] PC_FAULT = 5'd26;

  // control store: initial sample, then predict / gain / correct
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:  w = '{UOP_JSTART,   SRC_T,   SRC_T,   DST_T,   PC_RUN};
      5'd1:  w = '{UOP_JZERO,    SRC_C,   SRC_T,   DST_T,   PC_FAULT};
      5'd2:  w = '{UOP_DIV,      SRC_M,   SRC_C,   DST_X,   PC_NONE};
      5'd3:  w = '{UOP_DIV,      SRC_Q,   SRC_C,   DST_T,   PC_NONE};
      5'd4:  w = '{UOP_DIV,      SRC_T,   SRC_C,   DST_P,   PC_NONE};
      5'd5:  w = '{UOP_INITDONE, SRC_T,   SRC_T,   DST_T,   PC_NONE};
      5'd6:  w = '{UOP_MUL,      SRC_A,   SRC_X,   DST_T,   PC_NONE};
      5'd7:  w = '{UOP_MUL,      SRC_B,   SRC_U,   DST_XP,  PC_NONE};
      5'd8:  w = '{UOP_ADD,      SRC_T,   SRC_XP,  DST_XP,  PC_NONE};
      5'd9:  w = '{UOP_MUL,      SRC_A,   SRC_P,   DST_T,   PC_NONE};
      5'd10: w = '{UOP_MUL,      SRC_T,   SRC_A,   DST_T,   PC_NONE};
      5'd11: w = '{UOP_ADD,      SRC_T,   SRC_R,   DST_PP,  PC_NONE};
      5'd12: w = '{UOP_MUL,      SRC_C,   SRC_PP,  DST_T,   PC_NONE};
      5'd13: w = '{UOP_MUL,      SRC_T,   SRC_C,   DST_T,   PC_NONE};
      5'd14: w = '{UOP_ADD,      SRC_T,   SRC_Q,   DST_DEN, PC_NONE};
      5'd15: w = '{UOP_JZERO,    SRC_DEN, SRC_T,   DST_T,   PC_FAULT};
      5'd16: w = '{UOP_MUL,      SRC_PP,  SRC_C,   DST_T,   PC_NONE};
      5'd17: w = '{UOP_DIV,      SRC_T,   SRC_DEN, DST_K,   PC_NONE};
      5'd18: w = '{UOP_MUL,      SRC_C,   SRC_XP,  DST_T,   PC_NONE};
      5'd19: w = '{UOP_SUB,      SRC_M,   SRC_T,   DST_T,   PC_NONE};
      5'd20: w = '{UOP_MUL,      SRC_K,   SRC_T,   DST_T,   PC_NONE};
      5'd21: w = '{UOP_ADD,      SRC_XP,  SRC_T,   DST_X,   PC_NONE};
      5'd22: w = '{UOP_MUL,      SRC_K,   SRC_C,   DST_T,   PC_NONE};
      5'd23: w = '{UOP_MUL,      SRC_T,   SRC_PP,  DST_T,   PC_NONE};
      5'd24: w = '{UOP_SUB,      SRC_PP,  SRC_T,   DST_P,   PC_NONE};
      5'd25: w = '{UOP_DONE,     SRC_T,   SRC_T,   DST_T,   PC_NONE};
      5'd26: w = '{UOP_FAULT,    SRC_T,   SRC_T,   DST_T,   PC_NONE};
      default: w = '{UOP_FAULT,  SRC_T,   SRC_T,   DST_T,   PC_NONE};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/scalar_kalman_filter_core.sv]
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core
// One-dimensional Kalman filter, fixed point, run by a microcoded sequencer.
// A started sample runs eleven multiplies and one divide; the first sample runs
// three divides. Multiplies use a 16-bit digit multiplier. A new beat is taken
// only once the previous sample's result is loaded into the output register, so
// out_tready held low also holds the input off.
// Reset (synchronous, rst_n low) clears the estimate, covariance and started
// flag and restores the register defaults.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_core
  import skf_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,    // [31:0] measurement, [63:32] control
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,   // [31:0] estimate
  output logic                 out_tuser,   // [0] div_fault
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int DW  = DATA_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int EW  = (DW > FIELD_W) ? DW : FIELD_W;
  localparam int ND  = (DW + MDW - 1) / MDW;
  localparam int YW  = ND * MDW;
  localparam int QW  = DW + FB;
  localparam int PW  = 2 * DW;
  localparam int SW  = (PW > QW) ? PW : QW;
  localparam int MCW = $clog2(ND + 1);
  localparam int DCW = $clog2(QW + 1);

  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  function automatic logic signed [DW-1:0] sat_in(input logic [FIELD_W-1:0] v);
    logic signed [EW-1:0] ve;
    ve = EW'($signed(v));
    if (ve[EW-1:DW-1] == {(EW-DW+1){ve[EW-1]}}) begin
      return ve[DW-1:0];
    end
    return ve[EW-1] ? VMIN : VMAX;
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
    return a[DW-1] ? ({DW{1'b0}} - a) : a;
  endfunction

  function automatic logic signed [DW-1:0] from_mag(input logic [SW-1:0] m,
                                                     input logic neg);
    if (|m[SW-1:DW-1]) begin
      if (neg && (m[SW-1:DW-1] == {{(SW-DW){1'b0}}, 1'b1}) && ~|m[DW-2:0]) begin
        return VMIN;
      end
      return neg ? VMIN : VMAX;
    end
    return neg ? ({DW{1'b0}} - m[DW-1:0]) : m[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_sum(input logic signed [DW:0] s);
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? VMIN : VMAX;
    end
    return s[DW-1:0];
  endfunction

  // configuration
  logic [30:0]        proc_noise_r, meas_noise_r;
  logic [31:0]        state_gain_r, ctrl_gain_r, meas_gain_r;

  // sequencer and register file
  state_t             st_r, st_nxt;
  logic [PC_W-1:0]    pc_r, pc_nxt;
  uword_t             uw;
  logic signed [DW-1:0] m_r, u_r, x_r, p_r, t_r, xp_r, pp_r, den_r, k_r;
  logic               started_r, fault_r;
  logic signed [DW-1:0] opa, opb, wb_val;
  logic               wb_en, mul_load, div_load, end_op, out_load, accept;

  // multiplier
  logic [DW-1:0]      mx_r;
  logic [YW-1:0]      my_r;
  logic [PW-1:0]      macc_r;
  logic               mneg_r;
  logic [MCW-1:0]     mcnt_r;
  logic [DW+MDW-1:0]  mprod;

  // divider
  logic [DW-1:0]      dd_r, drem_r;
  logic [QW-1:0]      dq_r;
  logic               dneg_r;
  logic [DCW-1:0]     dcnt_r;
  logic [DW:0]        drs;
  logic               dge;

  // output
  logic               out_tvalid_r, fault_out_r;
  logic [31:0]        est_out_r;
  logic signed [EW-1:0] xe;

  function automatic logic signed [DW-1:0] operand(input src_t s);
    case (s)
      SRC_M:   return m_r;
      SRC_U:   return u_r;
      SRC_A:   return sat_in(state_gain_r);
      SRC_B:   return sat_in(ctrl_gain_r);
      SRC_C:   return sat_in(meas_gain_r);
      SRC_R:   return sat_in({1'b0, proc_noise_r});
      SRC_Q:   return sat_in({1'b0, meas_noise_r});
      SRC_X:   return x_r;
      SRC_P:   return p_r;
      SRC_T:   return t_r;
      SRC_XP:  return xp_r;
      SRC_PP:  return pp_r;
      SRC_DEN: return den_r;
      SRC_K:   return k_r;
      default: return t_r;
    endcase
  endfunction

  assign uw        = ucode(pc_r);
  assign opa       = operand(uw.src_a);
  assign opb       = operand(uw.src_b);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign mprod = mx_r * my_r[YW-1 -: MDW];
  assign drs   = {drem_r, dq_r[QW-1]};
  assign dge   = drs >= {1'b0, dd_r};

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (accept) st_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (uw.op)
          UOP_MUL:                          st_nxt = ST_MUL;
          UOP_DIV:                          st_nxt = ST_DIV;
          UOP_INITDONE, UOP_DONE, UOP_FAULT: st_nxt = ST_OUT;
          default:                          st_nxt = ST_EXEC;
        endcase
      end
      ST_MUL: begin
        if (mcnt_r == '0) st_nxt = ST_EXEC;
      end
      ST_DIV: begin
        if (dcnt_r == '0) st_nxt = ST_EXEC;
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    pc_nxt    = pc_r;
    wb_en     = 1'b0;
    wb_val    = t_r;
    mul_load  = 1'b0;
    div_load  = 1'b0;
    end_op    = 1'b0;
    out_load  = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        pc_nxt    = '0;
      end
      ST_EXEC: begin
        case (uw.op)
          UOP_ADD: begin
            wb_en  = 1'b1;
            wb_val = sat_sum({opa[DW-1], opa} + {opb[DW-1], opb});
            pc_nxt = pc_r + 1'b1;
          end
          UOP_SUB: begin
            wb_en  = 1'b1;
            wb_val = sat_sum({opa[DW-1], opa} - {opb[DW-1], opb});
            pc_nxt = pc_r + 1'b1;
          end
          UOP_MUL:    mul_load = 1'b1;
          UOP_DIV:    div_load = 1'b1;
          UOP_JSTART: pc_nxt = started_r ? uw.target : pc_r + 1'b1;
          UOP_JZERO:  pc_nxt = (opa == '0) ? uw.target : pc_r + 1'b1;
          default:    end_op = 1'b1;
        endcase
      end
      ST_MUL: begin
        if (mcnt_r == '0) begin
          wb_en  = 1'b1;
          wb_val = from_mag(SW'(macc_r >> FB), mneg_r);
          pc_nxt = pc_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (dcnt_r == '0) begin
          wb_en  = 1'b1;
          wb_val = from_mag(SW'(dq_r), dneg_r);
          pc_nxt = pc_r + 1'b1;
        end
      end
      ST_OUT: begin
        out_load = !out_tvalid_r || out_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      pc_r         <= '0;
      started_r    <= 1'b0;
      fault_r      <= 1'b0;
      x_r          <= '0;
      p_r          <= '0;
      out_tvalid_r <= 1'b0;
      proc_noise_r <= 31'd65536;
      meas_noise_r <= 31'd65536;
      state_gain_r <= 32'd65536;
      ctrl_gain_r  <= 32'd0;
      meas_gain_r  <= 32'd65536;
      mcnt_r       <= '0;
      dcnt_r       <= '0;
    end else begin
      st_r <= st_nxt;
      pc_r <= pc_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PROC_NOISE: proc_noise_r <= cfg_data[30:0];
          CFG_MEAS_NOISE: meas_noise_r <= cfg_data[30:0];
          CFG_STATE_GAIN: state_gain_r <= cfg_data;
          CFG_CTRL_GAIN:  ctrl_gain_r  <= cfg_data;
          CFG_MEAS_GAIN:  meas_gain_r  <= cfg_data;
          default: ;
        endcase
      end

      if (end_op) begin
        fault_r <= (uw.op == UOP_FAULT);
        if (uw.op == UOP_INITDONE) started_r <= 1'b1;
      end

      if (wb_en) begin
        case (uw.dst)
          DST_X: x_r <= wb_val;
          DST_P: p_r <= wb_val;
          default: ;
        endcase
      end

      if (mul_load) begin
        mcnt_r <= MCW'(ND);
      end else if (st_r == ST_MUL && mcnt_r != '0) begin
        mcnt_r <= mcnt_r - 1'b1;
      end

      if (div_load) begin
        dcnt_r <= DCW'(QW);
      end else if (st_r == ST_DIV && dcnt_r != '0) begin
        dcnt_r <= dcnt_r - 1'b1;
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      m_r <= sat_in(in_tdata[31:0]);
      u_r <= sat_in(in_tdata[63:32]);
    end

    if (wb_en) begin
      case (uw.dst)
        DST_T:   t_r   <= wb_val;
        DST_XP:  xp_r  <= wb_val;
        DST_PP:  pp_r  <= wb_val;
        DST_DEN: den_r <= wb_val;
        DST_K:   k_r   <= wb_val;
        default: ;
      endcase
    end

    if (mul_load) begin
      mx_r   <= mag(opa);
      my_r   <= YW'(mag(opb));
      macc_r <= '0;
      mneg_r <= opa[DW-1] ^ opb[DW-1];
    end else if (st_r == ST_MUL && mcnt_r != '0) begin
      macc_r <= (macc_r << MDW) + PW'(mprod);
      my_r   <= my_r << MDW;
    end

    if (div_load) begin
      dd_r   <= mag(opb);
      dq_r   <= {mag(opa), {FB{1'b0}}};
      drem_r <= '0;
      dneg_r <= opa[DW-1] ^ opb[DW-1];
    end else if (st_r == ST_DIV && dcnt_r != '0) begin
      drem_r <= dge ? DW'(drs - {1'b0, dd_r}) : drs[DW-1:0];
      dq_r   <= {dq_r[QW-2:0], dge};
    end

    if (out_load) begin
      est_out_r   <= (xe[EW-1:FIELD_W-1] == {(EW-FIELD_W+1){xe[EW-1]}}) ?
                     xe[FIELD_W-1:0] : (xe[EW-1] ? OUT_MIN : OUT_MAX);
      fault_out_r <= fault_r;
    end
  end

  assign xe         = EW'(x_r);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = est_out_r;
  assign out_tuser  = fault_out_r;

`ifndef NO_ASSERTIONS
  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> (pc_r < PC_W'(PROG_LEN)))
    else $error("sequencer left the program");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EXEC && uw.op == UOP_DIV) |-> (opb != '0))
    else $error("divide issued with zero divisor");

  a_started_by_init: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(started_r) |-> $past(st_r == ST_EXEC && uw.op == UOP_INITDONE))
    else $error("started set outside the initial sequence");
`endif

endmodule

[dv/tb_scalar_kalman_filter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scalar_kalman_filter_core
// Self-checking bench for the scalar Kalman filter core. A fixed-point model
// of the filter follows every accepted sample and register write. Each
// result beat is checked against the oldest expected estimate and fault flag.
// The run covers directed corner cases first, then random phases that
// reconfigure the filter between sample bursts, with random stalls on both
// streams until the last three phases.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_filter_core
  import skf_pkg::*;
();

  localparam longint VMAX        = 64'sd2147483647;
  localparam longint VMIN        = -VMAX - 1;
  localparam int     STALL_LIMIT = 5000;
  localparam int     PHASES      = 37;
  localparam int     PHASE_ITEMS = 50;

  typedef struct packed {
    logic [31:0] estimate;
    logic        div_fault;
  } kf_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [63:0]          in_tdata;    // [31:0] measurement, [63:32] control
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;   // [31:0] estimate
  logic                 out_tuser;   // [0] div_fault
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  // filter model state and registers
  longint kf_r = 65536;
  longint kf_q = 65536;
  longint kf_a = 65536;
  longint kf_b = 0;
  longint kf_c = 65536;
  longint kf_x = 0;
  longint kf_p = 0;
  bit     kf_started = 1'b0;

  kf_result_t pending_estimates[$];
  int         err_count   = 0;
  int         idle_cycles = 0;
  bit         calm        = 1'b0;

  scalar_kalman_filter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- fixed-point model ----------------
  function automatic longint sat(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    longint p;
    longint mg;
    p  = a * b;
    mg = (p < 0) ? -p : p;
    mg = mg >> 16;
    return sat((p < 0) ? -mg : mg);
  endfunction

  // b is never zero here
  function automatic longint q_div(longint a, longint b);
    longint n;
    longint d;
    longint q;
    n = ((a < 0) ? -a : a) <<< 16;
    d = (b < 0) ? -b : b;
    q = n / d;
    return sat(((a < 0) != (b < 0)) ? -q : q);
  endfunction

  function automatic longint q_add(longint a, longint b);
    return sat(a + b);
  endfunction

  function automatic longint q_sub(longint a, longint b);
    return sat(a - b);
  endfunction

  function automatic void kf_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      CFG_PROC_NOISE: kf_r = longint'(data[30:0]);
      CFG_MEAS_NOISE: kf_q = longint'(data[30:0]);
      CFG_STATE_GAIN: kf_a = longint'($signed(data));
      CFG_CTRL_GAIN:  kf_b = longint'($signed(data));
      CFG_MEAS_GAIN:  kf_c = longint'($signed(data));
      default: ;
    endcase
  endfunction

  function automatic kf_result_t kf_update(logic [31:0] meas_raw, logic [31:0] ctrl_raw);
    longint     m;
    longint     u;
    longint     xp;
    longint     pp;
    longint     den;
    longint     gain;
    longint     innov;
    kf_result_t r;
    m = longint'($signed(meas_raw));
    u = longint'($signed(ctrl_raw));
    r.div_fault = 1'b0;
    if (!kf_started) begin
      if (kf_c == 0) begin
        r.div_fault = 1'b1;
      end else begin
        kf_x = q_div(m, kf_c);
        kf_p = q_div(q_div(kf_q, kf_c), kf_c);
        kf_started = 1'b1;
      end
    end else begin
      xp  = q_add(q_mul(kf_a, kf_x), q_mul(kf_b, u));
      pp  = q_add(q_mul(q_mul(kf_a, kf_p), kf_a), kf_r);
      den = q_add(q_mul(q_mul(kf_c, pp), kf_c), kf_q);
      if (den == 0) begin
        r.div_fault = 1'b1;
      end else begin
        gain  = q_div(q_mul(pp, kf_c), den);
        innov = q_sub(m, q_mul(kf_c, xp));
        kf_x  = q_add(xp, q_mul(gain, innov));
        kf_p  = q_sub(pp, q_mul(q_mul(gain, kf_c), pp));
      end
    end
    r.estimate = kf_x[31:0];
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [31:0] rand_around(int centre, int spread);
    return 32'(centre + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic logic [31:0] rand_reg(logic [CFG_IDX_W-1:0] idx, bit tame);
    logic [31:0] mg;
    if (!tame) begin
      case ($urandom_range(0, 3))
        0:       return $urandom;
        1:       return 32'h7fff_ffff;
        2:       return 32'h8000_0000;
        default: return 32'h0;
      endcase
    end
    case (idx)
      CFG_PROC_NOISE: return $urandom_range(0, 32'h2_0000);
      CFG_MEAS_NOISE: return $urandom_range(32'h100, 32'h4_0000);
      CFG_STATE_GAIN: return rand_around(65536, 32'h2000);
      CFG_CTRL_GAIN:  return rand_around(0, 32'h8000);
      default: begin
        mg = $urandom_range(32'h8000, 32'h1_8000);
        return $urandom_range(0, 1) ? mg : -mg;
      end
    endcase
  endfunction

  task automatic hold_input(int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_sample(logic [31:0] meas, logic [31:0] ctrl);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {ctrl, meas};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_estimates.push_back(kf_update(meas, ctrl));
    if (!calm && $urandom_range(0, 2) == 0) hold_input($urandom_range(1, 14));
  endtask

  // sender holds off until every estimate is back
  task automatic wait_idle();
    hold_input(1);
    while (pending_estimates.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    kf_write(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------- tests ----------------
  task automatic test_unstarted_zero_gain();
    write_reg(CFG_MEAS_GAIN, 32'h0);
    send_sample(32'h7fff_ffff, 32'h8000_0000);
    send_sample($urandom, $urandom);
    wait_idle();
  endtask

  task automatic test_first_sample();
    write_reg(CFG_MEAS_GAIN, 32'hffff_0000);
    send_sample(32'h8000_0000, 32'h7fff_ffff);
    wait_idle();
  endtask

  task automatic test_default_filter();
    write_reg(CFG_MEAS_GAIN, 32'h0001_0000);
    send_sample(32'h0, 32'h0);
    send_sample(32'h7fff_ffff, 32'hffff_ffff);
    send_sample(32'h8000_0000, 32'h0);
    send_sample(32'h0000_0001, 32'h0000_0001);
    wait_idle();
  endtask

  task automatic test_control_saturation();
    write_reg(CFG_CTRL_GAIN, 32'h7fff_ffff);
    write_reg(CFG_STATE_GAIN, 32'h8000_0000);
    send_sample(32'h0001_0000, 32'h7fff_ffff);
    send_sample(32'hffff_0000, 32'h8000_0000);
    send_sample(32'h0, 32'h0);
    wait_idle();
  endtask

  task automatic test_zero_meas_gain();
    write_reg(CFG_STATE_GAIN, 32'h0001_0000);
    write_reg(CFG_CTRL_GAIN, 32'h0000_4000);
    write_reg(CFG_MEAS_GAIN, 32'h0);
    send_sample(32'h0005_0000, 32'h0002_0000);
    send_sample(32'hfffb_0000, 32'hfffe_0000);
    wait_idle();
    // zero denominator once Q is cleared as well
    write_reg(CFG_MEAS_NOISE, 32'h0);
    send_sample(32'h0003_0000, 32'h0001_0000);
    send_sample(32'h7fff_ffff, 32'h8000_0000);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_PROC_NOISE, 32'hffff_ffff);
    write_reg(CFG_MEAS_NOISE, 32'h0);
    write_reg(CFG_STATE_GAIN, 32'h7fff_ffff);
    write_reg(CFG_MEAS_GAIN, 32'h8000_0000);
    send_sample(32'h1234_5678, 32'h8765_4321);
    send_sample(32'h8000_0000, 32'h7fff_ffff);
    send_sample(32'h7fff_ffff, 32'h0);
    wait_idle();
    write_reg(CFG_PROC_NOISE, 32'h0);
    write_reg(CFG_MEAS_NOISE, 32'h7fff_ffff);
    write_reg(CFG_STATE_GAIN, 32'h0);
    write_reg(CFG_CTRL_GAIN, 32'h0);
    write_reg(CFG_MEAS_GAIN, 32'h7fff_ffff);
    send_sample(32'hdead_beef, 32'h5555_aaaa);
    send_sample(32'haaaa_5555, 32'h0);
    wait_idle();
  endtask

  task automatic test_spare_index();
    logic [CFG_IDX_W-1:0] spare;
    write_reg(CFG_PROC_NOISE, 32'h0001_0000);
    write_reg(CFG_MEAS_NOISE, 32'h0001_0000);
    write_reg(CFG_STATE_GAIN, 32'h0001_0000);
    write_reg(CFG_MEAS_GAIN, 32'h0001_0000);
    spare = CFG_MEAS_GAIN + CFG_IDX_W'($urandom_range(1, 3));
    write_reg(spare, $urandom);
    send_sample(32'h0002_0000, 32'h0);
    wait_idle();
  endtask

  task automatic test_random_phases();
    bit tame_regs;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph >= PHASES - 3) calm = 1'b1;
      wait_idle();
      tame_regs = $urandom_range(0, 4) != 0;
      for (int i = CFG_PROC_NOISE; i <= CFG_MEAS_GAIN; i++) begin
        write_reg(CFG_IDX_W'(i),
                  rand_reg(CFG_IDX_W'(i), tame_regs && $urandom_range(0, 5) != 0));
      end
      if ($urandom_range(0, 5) == 0)
        write_reg(CFG_MEAS_GAIN + CFG_IDX_W'($urandom_range(1, 3)), $urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 4) != 0)
          send_sample(rand_around(0, 64 << 16), rand_around(0, 8 << 16));
        else
          send_sample($urandom, $urandom);
      end
    end
  endtask

  // ---------------- result sink ----------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    kf_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_estimates.size() == 0) begin
        $error("unexpected result beat: estimate %h div_fault %b", out_tdata, out_tuser);
        err_count++;
      end else begin
        want = pending_estimates.pop_front();
        if (out_tdata !== want.estimate) begin
          $error("estimate: expected %h, got %h", want.estimate, out_tdata);
          err_count++;
        end
        if (out_tuser !== want.div_fault) begin
          $error("div_fault: expected %b, got %b", want.div_fault, out_tuser);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[scalar_kalman_filter_core] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_unstarted_zero_gain();
    test_first_sample();
    test_default_filter();
    test_control_saturation();
    test_zero_meas_gain();
    test_register_extremes();
    test_spare_index();
    test_random_phases();

    wait_idle();
    repeat (200) @(posedge clk);
    if (err_count == 0) begin
      $display("[scalar_kalman_filter_core] OK");
    end else begin
      $display("[scalar_kalman_filter_core] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/skf_pkg.sv
hw/rtl/scalar_kalman_filter_core.sv
dv/tb_scalar_kalman_filter_core.sv
